FILE: rtl/core/dep_pkg.sv
// shared types and constants of the dual encoder period and speed block
`default_nettype none

package dep_pkg;

    // fixed field widths
    localparam int CAPTURE_W  = 16;
    localparam int MODULUS_W  = 16;
    localparam int LIMIT_W    = 8;
    localparam int SCALE_W    = 31;
    localparam int PERIOD_W   = 25;
    localparam int SPEED_W    = 32;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_COUNTER_MODULUS      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STALL_OVERFLOW_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_SCALE          = 2'd2;

    localparam logic [MODULUS_W-1:0] MODULUS_RESET = 16'hFFFF;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 8'd10;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 31'd1000000;

    // one quotient bit per divider step
    localparam int DIV_STEPS = SCALE_W;

    // channel lanes
    localparam int NUM_CH   = 2;
    localparam int CH_LEFT  = 0;
    localparam int CH_RIGHT = 1;

    // period saturation bounds
    localparam logic signed [PERIOD_W-1:0] PERIOD_MAX = {1'b0, {(PERIOD_W-1){1'b1}}};
    localparam logic signed [PERIOD_W-1:0] PERIOD_MIN = {1'b1, {(PERIOD_W-1){1'b0}}};

    typedef struct packed {
        logic [MODULUS_W-1:0] counter_modulus;
        logic [LIMIT_W-1:0]   stall_overflow_limit;
        logic [SCALE_W-1:0]   speed_scale;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic prod;
        logic update;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/dep_ifs.sv
// item channel interfaces for timer events and speed results
`default_nettype none

interface dep_in_if;
    import dep_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 overflow_event;
    logic                 capture_left_event;
    logic [CAPTURE_W-1:0] capture_left_value;
    logic                 direction_left_pin;
    logic                 capture_right_event;
    logic [CAPTURE_W-1:0] capture_right_value;
    logic                 direction_right_pin;

    modport source (
        output valid, overflow_event, capture_left_event, capture_left_value,
               direction_left_pin, capture_right_event, capture_right_value,
               direction_right_pin,
        input  ready
    );

    modport sink (
        input  valid, overflow_event, capture_left_event, capture_left_value,
               direction_left_pin, capture_right_event, capture_right_value,
               direction_right_pin,
        output ready
    );
endinterface

interface dep_out_if;
    import dep_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [PERIOD_W-1:0] left_period;
    logic signed [PERIOD_W-1:0] right_period;
    logic signed [SPEED_W-1:0]  left_speed;
    logic signed [SPEED_W-1:0]  right_speed;

    modport source (
        output valid, left_period, right_period, left_speed, right_speed,
        input  ready
    );

    modport sink (
        input  valid, left_period, right_period, left_speed, right_speed,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/dep_cfg_regs.sv
// apb configuration registers: modulus, stall limit and speed scale
`default_nettype none

module dep_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dep_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dep_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dep_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output dep_pkg::cfg_t                       cfg
);
    import dep_pkg::*;

    logic [MODULUS_W-1:0] modulus_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // word address decode
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            limit_reg   <= LIMIT_RESET;
            scale_reg   <= SCALE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_COUNTER_MODULUS:      modulus_reg <= pwdata[MODULUS_W-1:0];
                REG_STALL_OVERFLOW_LIMIT: limit_reg   <= pwdata[LIMIT_W-1:0];
                REG_SPEED_SCALE:          scale_reg   <= pwdata[SCALE_W-1:0];
                default:                  ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_COUNTER_MODULUS:      prdata = APB_DATA_W'(modulus_reg);
            REG_STALL_OVERFLOW_LIMIT: prdata = APB_DATA_W'(limit_reg);
            REG_SPEED_SCALE:          prdata = APB_DATA_W'(scale_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.counter_modulus      = modulus_reg;
    assign cfg.stall_overflow_limit = limit_reg;
    assign cfg.speed_scale          = scale_reg;

endmodule

`default_nettype wire

FILE: rtl/core/dep_ctrl.sv
// controller: sequences overflow, capture, division and result load per item
`default_nettype none

module dep_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output dep_pkg::cmd_t      cmd,
    input  wire dep_pkg::sts_t sts
);
    import dep_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    localparam int               CNT_W    = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_ready_reg;
    logic             accept;

    assign accept   = in_valid & in_ready_reg;
    assign in_ready = in_ready_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, step count and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    // an accepted item always starts with the product step
    a_accept_to_prod: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_PROD)
        else $error("accepted item did not move to product step");

    // ready mirrors the idle state
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg == (state_reg == ST_IDLE))
        else $error("ready out of step with controller state");

    // divider runs exactly the quotient width
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && cnt_reg == CNT_LAST |=> state_reg == ST_FINISH)
        else $error("divider sequence overran its step count");

endmodule

`default_nettype wire

FILE: rtl/core/dep_datapath.sv
// datapath: overflow counts, period measurement, restoring dividers, result register
`default_nettype none

module dep_datapath #(
    parameter int COUNTER_WIDTH        = 16,
    parameter int OVERFLOW_COUNT_WIDTH = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dep_pkg::cmd_t                      cmd,
    output dep_pkg::sts_t                           sts,
    input  wire dep_pkg::cfg_t                      cfg,
    input  wire logic                               overflow_event,
    input  wire logic                               capture_left_event,
    input  wire logic        [dep_pkg::CAPTURE_W-1:0] capture_left_value,
    input  wire logic                               direction_left_pin,
    input  wire logic                               capture_right_event,
    input  wire logic        [dep_pkg::CAPTURE_W-1:0] capture_right_value,
    input  wire logic                               direction_right_pin,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic signed      [dep_pkg::PERIOD_W-1:0] left_period,
    output logic signed      [dep_pkg::PERIOD_W-1:0] right_period,
    output logic signed      [dep_pkg::SPEED_W-1:0]  left_speed,
    output logic signed      [dep_pkg::SPEED_W-1:0]  right_speed
);
    import dep_pkg::*;

    localparam int CW     = COUNTER_WIDTH;
    localparam int OW     = OVERFLOW_COUNT_WIDTH;
    localparam int EXT_W  = (CW > CAPTURE_W) ? CW : CAPTURE_W;
    localparam int PROD_W = OW + MODULUS_W;
    localparam int RAW_W  = ((CW > PROD_W) ? CW : PROD_W) + 2;
    localparam int SUM_W  = (RAW_W > PERIOD_W + 1) ? RAW_W : PERIOD_W + 1;
    localparam int CMP_W  = (OW > LIMIT_W) ? OW : LIMIT_W;
    localparam int REM_W  = PERIOD_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(PERIOD_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(PERIOD_MIN);

    // per-lane views of the incoming item
    logic [CAPTURE_W-1:0] cap_val_in [NUM_CH];
    logic                 cap_evt_in [NUM_CH];
    logic                 neg_in     [NUM_CH];

    assign cap_val_in[CH_LEFT]  = capture_left_value;
    assign cap_val_in[CH_RIGHT] = capture_right_value;
    assign cap_evt_in[CH_LEFT]  = capture_left_event;
    assign cap_evt_in[CH_RIGHT] = capture_right_event;
    assign neg_in[CH_LEFT]      = ~direction_left_pin;
    assign neg_in[CH_RIGHT]     = direction_right_pin;

    logic                       ovf_evt_reg;
    logic                       cap_evt_reg    [NUM_CH];
    logic [CW-1:0]              cap_val_reg    [NUM_CH];
    logic                       neg_reg        [NUM_CH];
    logic [CW-1:0]              last_reg       [NUM_CH];
    logic [OW-1:0]              ovf_cnt_reg    [NUM_CH];
    logic signed [PERIOD_W-1:0] period_reg     [NUM_CH];
    logic [PROD_W-1:0]          prod_reg       [NUM_CH];
    logic signed [PERIOD_W-1:0] period_out_reg [NUM_CH];
    logic signed [SPEED_W-1:0]  speed_out_reg  [NUM_CH];
    logic                       out_valid_reg;

    // overflow flag of the held item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ovf_evt_reg <= overflow_event;
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        logic [EXT_W-1:0]          cap_ext;
        logic [OW-1:0]             ovf_eff;
        logic                      stall;
        logic signed [SUM_W-1:0]   sum_pos;
        logic signed [SUM_W-1:0]   sum_adj;
        logic signed [PERIOD_W-1:0] period_new;
        logic [PERIOD_W-1:0]       mag;
        logic [PERIOD_W-1:0]       div_d_reg;
        logic [REM_W-1:0]          rem_reg;
        logic [SCALE_W-1:0]        quo_reg;
        logic                      sgn_reg;
        logic                      zero_reg;
        logic [REM_W-1:0]          trial;
        logic                      fits;
        logic [SPEED_W-1:0]        q_ext;
        logic [SPEED_W-1:0]        speed_val;

        assign cap_ext = EXT_W'(cap_val_in[ch]);

        // saturating overflow count and stall test
        assign ovf_eff = !ovf_evt_reg ? ovf_cnt_reg[ch]
                       : (ovf_cnt_reg[ch] == '1) ? ovf_cnt_reg[ch]
                       : ovf_cnt_reg[ch] + OW'(1);
        assign stall = CMP_W'(ovf_eff) > CMP_W'(cfg.stall_overflow_limit);

        // signed period with direction and saturation
        assign sum_pos = signed'(SUM_W'(cap_val_reg[ch])) - signed'(SUM_W'(last_reg[ch]))
                       + signed'(SUM_W'(prod_reg[ch]));
        assign sum_adj = neg_reg[ch] ? -sum_pos : sum_pos;

        always_comb
        begin
            priority if (sum_adj > SUM_MAX)
            begin
                period_new = PERIOD_MAX;
            end
            else if (sum_adj < SUM_MIN)
            begin
                period_new = PERIOD_MIN;
            end
            else
            begin
                period_new = sum_adj[PERIOD_W-1:0];
            end
        end

        // item capture fields
        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                cap_evt_reg[ch] <= cap_evt_in[ch];
                cap_val_reg[ch] <= cap_ext[CW-1:0];
                neg_reg[ch]     <= neg_in[ch];
            end
        end

        // overflow product, one multiply per lane
        always_ff @(posedge clk)
        begin
            if (cmd.prod)
            begin
                prod_reg[ch] <= PROD_W'(ovf_eff) * PROD_W'(cfg.counter_modulus);
            end
        end

        // lane state: last capture, overflow count, period
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                last_reg[ch]    <= '0;
                ovf_cnt_reg[ch] <= '0;
                period_reg[ch]  <= '0;
            end
            else if (cmd.prod)
            begin
                ovf_cnt_reg[ch] <= ovf_eff;
                if (ovf_evt_reg && stall)
                begin
                    period_reg[ch] <= '0;
                end
            end
            else if (cmd.update && cap_evt_reg[ch])
            begin
                period_reg[ch]  <= period_new;
                last_reg[ch]    <= cap_val_reg[ch];
                ovf_cnt_reg[ch] <= '0;
            end
        end

        // restoring divider: scale over period magnitude, one bit per step
        assign mag   = period_reg[ch][PERIOD_W-1] ? unsigned'(-period_reg[ch])
                                                  : unsigned'(period_reg[ch]);
        assign trial = {rem_reg[REM_W-2:0], quo_reg[SCALE_W-1]};
        assign fits  = trial >= {1'b0, div_d_reg};

        always_ff @(posedge clk)
        begin
            if (cmd.div_load)
            begin
                div_d_reg <= mag;
                rem_reg   <= '0;
                quo_reg   <= cfg.speed_scale;
                sgn_reg   <= period_reg[ch][PERIOD_W-1];
                zero_reg  <= (period_reg[ch] == '0);
            end
            else if (cmd.div_step)
            begin
                rem_reg <= fits ? trial - {1'b0, div_d_reg} : trial;
                quo_reg <= {quo_reg[SCALE_W-2:0], fits};
            end
        end

        assign q_ext     = SPEED_W'(quo_reg);
        assign speed_val = zero_reg ? '0 : (sgn_reg ? -q_ext : q_ext);

        // result payload
        always_ff @(posedge clk)
        begin
            if (cmd.out_load)
            begin
                period_out_reg[ch] <= period_reg[ch];
                speed_out_reg[ch]  <= signed'(speed_val);
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign left_period  = period_out_reg[CH_LEFT];
    assign right_period = period_out_reg[CH_RIGHT];
    assign left_speed   = speed_out_reg[CH_LEFT];
    assign right_speed  = speed_out_reg[CH_RIGHT];

    // a capture restarts its overflow count
    a_capture_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && cap_evt_reg[CH_LEFT] |=> ovf_cnt_reg[CH_LEFT] == '0)
        else $error("left overflow count not cleared by capture");

    // zero period gives zero speed
    a_zero_period_speed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && period_reg[CH_RIGHT] == '0 |=> speed_out_reg[CH_RIGHT] == '0)
        else $error("right speed nonzero for zero period");

endmodule

`default_nettype wire

FILE: rtl/core/dual_encoder_period_speed.sv
// top level of the dual wheel encoder period and speed measurement block
//
// events carries one timer service item: an overflow flag, then a left and a
// right capture, each with a counter value and a direction pin. Every item
// accepted yields exactly one item on results with both signed periods and
// both speeds (speed_scale divided by the period, truncated, 0 for period 0).
// The apb port writes counter_modulus, stall_overflow_limit and speed_scale
// at byte addresses 0, 4 and 8; write them only while the block is idle.
// After acceptance the controller runs one product step, one period update,
// one divider load and 31 steps of the two one-bit-per-cycle restoring
// dividers that run side by side, then the result load; a new item is taken
// only once the previous one has loaded its result.
// The result sits in an output register, so the next item is taken while
// an earlier result waits; if results is still stalled when the next result
// is ready, the controller holds in its finish step until it drains.
// Reset clears the capture, overflow and period state, loads the register
// defaults, empties the output register and raises events.ready.
`default_nettype none

module dual_encoder_period_speed #(
    parameter int COUNTER_WIDTH        = 16,
    parameter int OVERFLOW_COUNT_WIDTH = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dep_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dep_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dep_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    dep_in_if.sink                              events,
    dep_out_if.source                           results
);
    import dep_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    // configuration registers
    dep_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    dep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (events.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    assign events.ready = in_ready;

    // measurement and division
    dep_datapath #(
        .COUNTER_WIDTH        (COUNTER_WIDTH),
        .OVERFLOW_COUNT_WIDTH (OVERFLOW_COUNT_WIDTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg                 (cfg),
        .overflow_event      (events.overflow_event),
        .capture_left_event  (events.capture_left_event),
        .capture_left_value  (events.capture_left_value),
        .direction_left_pin  (events.direction_left_pin),
        .capture_right_event (events.capture_right_event),
        .capture_right_value (events.capture_right_value),
        .direction_right_pin (events.direction_right_pin),
        .out_ready           (results.ready),
        .out_valid           (results.valid),
        .left_period         (results.left_period),
        .right_period        (results.right_period),
        .left_speed          (results.left_speed),
        .right_speed         (results.right_speed)
    );

endmodule

`default_nettype wire

FILE: dv/dual_encoder_period_speed_test.sv
// testbench for the dual encoder period and speed block with its own speed predictor
`default_nettype none

module dual_encoder_period_speed_test;
    import dep_pkg::*;

    localparam longint CYCLE_LIMIT  = 1000000;
    localparam int     SETTLE_TICKS = 40;
    localparam int     MAX_REPORTS  = 10;
    localparam logic [SCALE_W-1:0] SCALE_TOP = {SCALE_W{1'b1}};

    // one timer service item as it goes into the block
    typedef struct packed {
        logic                 overflow;
        logic                 cap_left;
        logic [CAPTURE_W-1:0] val_left;
        logic                 dir_left;
        logic                 cap_right;
        logic [CAPTURE_W-1:0] val_right;
        logic                 dir_right;
    } timer_event_t;

    // one result item of periods and speeds
    typedef struct packed {
        logic signed [PERIOD_W-1:0] left_period;
        logic signed [PERIOD_W-1:0] right_period;
        logic signed [SPEED_W-1:0]  left_speed;
        logic signed [SPEED_W-1:0]  right_speed;
    } wheel_speeds_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dep_in_if  events_if ();
    dep_out_if results_if ();

    dual_encoder_period_speed uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .events  (events_if),
        .results (results_if)
    );

    // register copies used by the predictor
    logic [MODULUS_W-1:0] cfg_modulus;
    logic [LIMIT_W-1:0]   cfg_limit;
    logic [SCALE_W-1:0]   cfg_scale;

    // predictor channel state
    logic [CAPTURE_W-1:0]       last_cap_left;
    logic [CAPTURE_W-1:0]       last_cap_right;
    logic [7:0]                 ovf_left;
    logic [7:0]                 ovf_right;
    logic signed [PERIOD_W-1:0] per_left;
    logic signed [PERIOD_W-1:0] per_right;

    wheel_speeds_t pending_speeds[$];

    int     send_idle_pct;
    int     recv_stall_pct;
    int     events_sent;
    int     results_checked;
    int     reg_writes;
    int     mismatches;
    longint cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_speeds.size());
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        wheel_speeds_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            results_checked++;
            if (pending_speeds.size() == 0)
            begin
                note_mismatch("result with nothing pending", 0, 0);
            end
            else
            begin
                want = pending_speeds.pop_front();
                if (results_if.left_period !== want.left_period)
                    note_mismatch("left_period", want.left_period, results_if.left_period);
                if (results_if.right_period !== want.right_period)
                    note_mismatch("right_period", want.right_period, results_if.right_period);
                if (results_if.left_speed !== want.left_speed)
                    note_mismatch("left_speed", want.left_speed, results_if.left_speed);
                if (results_if.right_speed !== want.right_speed)
                    note_mismatch("right_speed", want.right_speed, results_if.right_speed);
            end
        end
    end

    // signed edge period with direction and saturation
    function automatic logic signed [PERIOD_W-1:0] edge_period(
        input logic [CAPTURE_W-1:0] value,
        input logic [CAPTURE_W-1:0] last,
        input logic [7:0]           ovf,
        input logic                 negate
    );
        longint p;
        p = longint'(value) - longint'(last) + longint'(ovf) * longint'(cfg_modulus);
        if (negate)
            p = -p;
        if (p > longint'(PERIOD_MAX))
            p = longint'(PERIOD_MAX);
        if (p < longint'(PERIOD_MIN))
            p = longint'(PERIOD_MIN);
        return p[PERIOD_W-1:0];
    endfunction

    // scale over period, truncated toward zero, zero for a zero period
    function automatic logic signed [SPEED_W-1:0] wheel_speed(
        input logic signed [PERIOD_W-1:0] period
    );
        longint q;
        if (period == 0)
            return '0;
        q = longint'(cfg_scale) / longint'(period);
        return q[SPEED_W-1:0];
    endfunction

    function automatic logic [7:0] bump_overflows(input logic [7:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    // advance the channel state by one item and give the expected result
    task automatic predict_speeds(input timer_event_t ev, output wheel_speeds_t res);
        if (ev.overflow)
        begin
            ovf_left  = bump_overflows(ovf_left);
            ovf_right = bump_overflows(ovf_right);
            if (ovf_left > cfg_limit)
                per_left = '0;
            if (ovf_right > cfg_limit)
                per_right = '0;
        end
        if (ev.cap_left)
        begin
            per_left      = edge_period(ev.val_left, last_cap_left, ovf_left, !ev.dir_left);
            last_cap_left = ev.val_left;
            ovf_left      = '0;
        end
        if (ev.cap_right)
        begin
            per_right      = edge_period(ev.val_right, last_cap_right, ovf_right, ev.dir_right);
            last_cap_right = ev.val_right;
            ovf_right      = '0;
        end
        res.left_period  = per_left;
        res.right_period = per_right;
        res.left_speed   = wheel_speed(per_left);
        res.right_speed  = wheel_speed(per_right);
    endtask

    // present one item, wait for the handshake, then record its prediction
    task automatic send_event(input timer_event_t ev);
        wheel_speeds_t want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            events_if.valid <= 1'b0;
            @(negedge clk);
        end
        events_if.valid               <= 1'b1;
        events_if.overflow_event      <= ev.overflow;
        events_if.capture_left_event  <= ev.cap_left;
        events_if.capture_left_value  <= ev.val_left;
        events_if.direction_left_pin  <= ev.dir_left;
        events_if.capture_right_event <= ev.cap_right;
        events_if.capture_right_value <= ev.val_right;
        events_if.direction_right_pin <= ev.dir_right;
        do
            @(posedge clk);
        while (!events_if.ready);
        predict_speeds(ev, want);
        pending_speeds.push_back(want);
        events_sent++;
    endtask

    function automatic timer_event_t make_event(
        input logic ovf,
        input logic cl, input logic [CAPTURE_W-1:0] vl, input logic dl,
        input logic cr, input logic [CAPTURE_W-1:0] vr, input logic dr
    );
        timer_event_t ev;
        ev.overflow  = ovf;
        ev.cap_left  = cl;
        ev.val_left  = vl;
        ev.dir_left  = dl;
        ev.cap_right = cr;
        ev.val_right = vr;
        ev.dir_right = dr;
        return ev;
    endfunction

    // stop sending and let every outstanding result drain
    task automatic wait_until_idle();
        @(negedge clk);
        events_if.valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // apb read: setup then access, data taken at the ready edge
    task automatic read_register(input logic [REG_IDX_W-1:0] idx,
                                 output logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [APB_DATA_W-1:0] mirrored_register(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_COUNTER_MODULUS:      return APB_DATA_W'(cfg_modulus);
            REG_STALL_OVERFLOW_LIMIT: return APB_DATA_W'(cfg_limit);
            REG_SPEED_SCALE:          return APB_DATA_W'(cfg_scale);
            default:                  return '0;
        endcase
    endfunction

    // apb write, mirrored into the predictor, then read back
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_COUNTER_MODULUS:      cfg_modulus = value[MODULUS_W-1:0];
            REG_STALL_OVERFLOW_LIMIT: cfg_limit   = value[LIMIT_W-1:0];
            REG_SPEED_SCALE:          cfg_scale   = value[SCALE_W-1:0];
            default:                  ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_register(idx, got);
        if (got !== mirrored_register(idx))
            note_mismatch("register readback", mirrored_register(idx), got);
    endtask

    task automatic configure(input logic [MODULUS_W-1:0] modulus,
                             input logic [LIMIT_W-1:0] limit,
                             input logic [SCALE_W-1:0] scale);
        wait_until_idle();
        write_register(REG_COUNTER_MODULUS, APB_DATA_W'(modulus));
        write_register(REG_STALL_OVERFLOW_LIMIT, APB_DATA_W'(limit));
        write_register(REG_SPEED_SCALE, APB_DATA_W'(scale));
    endtask

    // registers come out of reset at their defaults
    task automatic test_register_defaults();
        logic [APB_DATA_W-1:0] got;
        logic [REG_IDX_W-1:0]  idx;
        for (int i = 0; i < 3; i++)
        begin
            idx = REG_IDX_W'(i);
            read_register(idx, got);
            if (got !== mirrored_register(idx))
                note_mismatch("register after reset", mirrored_register(idx), got);
        end
    endtask

    // field extremes, direction signs, stall, fresh period after stall, zero setups
    task automatic test_directed_events();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_event(make_event(0, 0, 16'h0000, 0, 0, 16'h0000, 0));
        send_event(make_event(0, 1, 16'd1000, 1, 0, 16'h0000, 0));
        send_event(make_event(0, 0, 16'hFFFF, 1, 1, 16'd500, 0));
        send_event(make_event(0, 1, 16'h0000, 0, 1, 16'h0000, 1));
        send_event(make_event(1, 0, 16'h0000, 0, 0, 16'h0000, 0));
        send_event(make_event(1, 1, 16'hFFFF, 1, 1, 16'hFFFF, 1));
        // eleven overflows pass the default limit of ten on both channels
        repeat (11) send_event(make_event(1, 0, 16'h0000, 0, 0, 16'h0000, 0));
        send_event(make_event(0, 1, 16'h0001, 0, 1, 16'hFFFE, 0));

        // limit 0 stalls on every overflow, period of one gives the largest speed
        configure(16'd1, 8'd0, SCALE_TOP);
        send_event(make_event(0, 1, 16'd100, 1, 1, 16'd100, 0));
        send_event(make_event(0, 1, 16'd101, 1, 1, 16'd101, 1));
        send_event(make_event(1, 0, 16'h0000, 0, 0, 16'h0000, 0));
        send_event(make_event(1, 1, 16'h0000, 1, 0, 16'h0000, 0));

        // zero modulus and zero scale
        configure(16'd0, 8'd3, '0);
        send_event(make_event(1, 1, 16'd5, 0, 1, 16'd7, 1));
        send_event(make_event(1, 1, 16'hFFFF, 1, 1, 16'h0000, 0));
    endtask

    // a long overflow run pins both counts at their maximum
    task automatic test_overflow_saturation();
        configure(16'hFFFF, 8'hFF, SCALE_W'(1000000));
        send_event(make_event(0, 1, 16'hFFFF, 1, 1, 16'hFFFF, 0));
        repeat (270) send_event(make_event(1, 0, 16'h0000, 0, 0, 16'h0000, 0));
        send_event(make_event(0, 1, 16'hFFFE, 1, 1, 16'h0000, 1));
        send_event(make_event(1, 1, 16'hFFFF, 0, 1, 16'hFFFF, 0));
    endtask

    function automatic logic [CAPTURE_W-1:0] random_capture();
        if ($urandom_range(99) < 8)
            return $urandom_range(1) ? {CAPTURE_W{1'b1}} : '0;
        return CAPTURE_W'($urandom);
    endfunction

    function automatic timer_event_t random_event(input logic overflow_only);
        timer_event_t ev;
        ev.overflow  = overflow_only || ($urandom_range(99) < 25);
        ev.cap_left  = !overflow_only && ($urandom_range(99) < 55);
        ev.val_left  = random_capture();
        ev.dir_left  = 1'($urandom_range(1));
        ev.cap_right = !overflow_only && ($urandom_range(99) < 55);
        ev.val_right = random_capture();
        ev.dir_right = 1'($urandom_range(1));
        return ev;
    endfunction

    // random traffic under one setup and one pressure mix, with overflow bursts
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [MODULUS_W-1:0] modulus,
                                       input logic [LIMIT_W-1:0] limit,
                                       input logic [SCALE_W-1:0] scale,
                                       input int count);
        int sent;
        int burst;
        configure(modulus, limit, scale);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 6)
            begin
                // run of overflows, at most three past the stall limit and at most 40 long
                burst = $urandom_range(1, (int'(cfg_limit) + 3 > 40) ? 40 : int'(cfg_limit) + 3);
                repeat (burst) send_event(random_event(1'b1));
                sent += burst;
            end
            else
            begin
                send_event(random_event(1'b0));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n                          = 1'b0;
        psel                           = 1'b0;
        penable                        = 1'b0;
        pwrite                         = 1'b0;
        paddr                          = '0;
        pwdata                         = '0;
        events_if.valid                = 1'b0;
        events_if.overflow_event       = 1'b0;
        events_if.capture_left_event   = 1'b0;
        events_if.capture_left_value   = '0;
        events_if.direction_left_pin   = 1'b0;
        events_if.capture_right_event  = 1'b0;
        events_if.capture_right_value  = '0;
        events_if.direction_right_pin  = 1'b0;
        results_if.ready               = 1'b0;
        send_idle_pct                  = 0;
        recv_stall_pct                 = 0;
        events_sent                    = 0;
        results_checked                = 0;
        reg_writes                     = 0;
        mismatches                     = 0;
        cycles                         = 0;
        cfg_modulus                    = MODULUS_RESET;
        cfg_limit                      = LIMIT_RESET;
        cfg_scale                      = SCALE_RESET;
        last_cap_left                  = '0;
        last_cap_right                 = '0;
        ovf_left                       = '0;
        ovf_right                      = '0;
        per_left                       = '0;
        per_right                      = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_defaults();
        test_directed_events();
        test_overflow_saturation();
        test_random_traffic(0, 0, MODULUS_W'($urandom_range(1, 65535)),
                            LIMIT_W'($urandom_range(0, 15)), SCALE_TOP, 375);
        test_random_traffic(46, 0, 16'd1, 8'd0, 31'd1, 375);
        test_random_traffic(0, 46, 16'hFFFF, 8'hFF,
                            SCALE_W'($urandom_range(1, 32'h7FFF_FFFF)), 375);
        test_random_traffic(15, 15, MODULUS_W'($urandom_range(1, 65535)),
                            LIMIT_W'($urandom_range(0, 40)),
                            SCALE_W'($urandom_range(1, 32'h7FFF_FFFF)), 375);
        wait_until_idle();

        if (pending_speeds.size() != 0)
            note_mismatch("results never delivered", 0, pending_speeds.size());
        $display("covered %0d timer events and checked %0d speed results, %0d mismatches",
                 events_sent, results_checked, mismatches);
        $display("%0d register writes, four pressure mixes, stall and saturation runs",
                 reg_writes);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
